// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the colour key span extractor RTL.
// Defining NO_ASSERTIONS turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising edge outside reset.
`define CKSE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// The consequent must hold whenever the antecedent holds.
`define CKSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

`else

`define CKSE_ASSERT(label, clk, rst_n, prop)
`define CKSE_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/ckse_pkg.sv -----
// Shared types and constants of the colour key span extractor.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ckse_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int BATCH_SIZE = 2000;

	localparam int CHAN_W = 8;
	localparam int NUM_CHAN = 3;
	localparam int PIX_W = CHAN_W * NUM_CHAN;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

	localparam int COL_W = 12;
	localparam int ROW_W = 12;
	localparam int POS_W = 13;
	localparam int CNT_W = 11;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;

	localparam logic KIND_SPAN  = 1'b0;
	localparam logic KIND_BATCH = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_color;
		logic             row_end;
		logic             frame_end;
	} pixel_t;

	typedef struct packed {
		logic             record_kind;
		logic [COL_W-1:0] span_start;
		logic [POS_W-1:0] span_stop;
		logic [ROW_W-1:0] span_row;
		logic [POS_W-1:0] box_left;
		logic [POS_W-1:0] box_top;
		logic [POS_W-1:0] box_right;
		logic [POS_W-1:0] box_bottom;
		logic [CNT_W-1:0] batch_count;
		logic             last;
	} record_t;

	// What the front hands to the back for one pixel.
	typedef struct packed {
		logic             has_span;
		logic [COL_W-1:0] span_start;
		logic [POS_W-1:0] span_stop;
		logic [ROW_W-1:0] span_row;
		logic             frame_end;
	} span_event_t;

endpackage
`default_nettype wire

// ----- rtl/core/color_key_span_extractor.sv -----
// Top level of the colour key span extractor: configuration registers, front, queue, back.
// Depends on ckse_pkg, ckse_front, ckse_fifo, ckse_back and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The block takes one pixel per clock in raster order and returns a record for every
// maximal run of opaque pixels in a row, plus a batch record each time a batch of spans
// fills up and a final batch record at frame end. A pixel beat is classified and its
// run state advanced in the cycle it is accepted; any resulting span or frame end is
// written into a four-entry event queue. The back drains that queue, producing one
// record beat per clock into an output register unless the record consumer stalls;
// a plain span passes through its queue entry and then the output register. A full
// batch or a frame end each adds a batch record that the back must send, a delay
// which the queue absorbs; pixel_ready drops only while the queue is full, i.e. when
// the record consumer stalls or when batch and frame records arrive faster than one
// per pixel. With no consumer stall the sustained rate is one pixel per clock.
// Configuration beats are always accepted and take effect from the next pixel; they
// must only be issued while the block is idle. An unknown register index is ignored.
module color_key_span_extractor (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pixel_valid,
	output logic                               pixel_ready,
	input  wire ckse_pkg::pixel_t              pixel,
	output logic                               record_valid,
	input  wire logic                          record_ready,
	output ckse_pkg::record_t                  record,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ckse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ckse_pkg::PIX_W-1:0]     cfg_data
);
	import ckse_pkg::*;

	logic [PIX_W-1:0] key_color_q;
	logic [PIX_W-1:0] tolerance_q;

	logic        queue_full;
	logic        ev_push;
	span_event_t ev_in;
	logic        ev_pop;
	logic        ev_valid;
	span_event_t ev_head;

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_color_q <= {PIX_W{1'b1}};
			tolerance_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_COLOR: key_color_q <= cfg_data;
				CFG_TOLERANCE: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: classifies each pixel and tracks the open run within the row.
	ckse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.key_color   (key_color_q),
		.tolerance   (tolerance_q),
		.queue_full  (queue_full),
		.ev_push     (ev_push),
		.ev          (ev_in)
	);

	// Decouples the two halves so that each may stall on its own.
	ckse_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (ev_push),
		.push_data  (ev_in),
		.full       (queue_full),
		.pop        (ev_pop),
		.head_valid (ev_valid),
		.head       (ev_head)
	);

	// Back: owns the batch box and count and sequences up to three records per event.
	ckse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (ev_valid),
		.ev           (ev_head),
		.ev_pop       (ev_pop),
		.record_valid (record_valid),
		.record_ready (record_ready),
		.record       (record)
	);

	// A span always covers at least one column.
	`CKSE_ASSERT_IMPL(a_span_nonempty, clk, arst_n, record_valid && (record.record_kind == KIND_SPAN), record.span_stop > {1'b0, record.span_start})

	// A batch never holds more spans than the batch size.
	`CKSE_ASSERT_IMPL(a_count_bound, clk, arst_n, record_valid && (record.record_kind == KIND_BATCH), record.batch_count <= CNT_W'(BATCH_SIZE))

	// An empty batch reports the empty box.
	`CKSE_ASSERT_IMPL(a_empty_box, clk, arst_n, record_valid && (record.record_kind == KIND_BATCH) && (record.batch_count == '0), (record.box_left == POS_W'(MAX_WIDTH)) && (record.box_right == '0))

	// The front only pushes into a queue with room.
	`CKSE_ASSERT(a_no_overflow, clk, arst_n, !(ev_push && queue_full))

endmodule
`default_nettype wire

// ----- rtl/core/ckse_front.sv -----
// Front of the span extractor: colour key test, column and row tracking, run detection.
// Depends on ckse_pkg; pushes span events into ckse_fifo.
`timescale 1ns / 1ps
`default_nettype none
module ckse_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      pixel_valid,
	output logic                           pixel_ready,
	input  wire ckse_pkg::pixel_t          pixel,
	input  wire logic [ckse_pkg::PIX_W-1:0] key_color,
	input  wire logic [ckse_pkg::PIX_W-1:0] tolerance,
	input  wire logic                      queue_full,
	output logic                           ev_push,
	output ckse_pkg::span_event_t          ev
);
	import ckse_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             run_open_q;
	logic [COL_W-1:0] run_begin_q;

	logic             accept;
	logic             transp;
	logic             rend;
	logic [COL_W-1:0] begin_col;

	assign pixel_ready = !queue_full;
	assign accept = pixel_valid && pixel_ready;

	// Transparent when every channel sits in [key, min(max, key + tol)].
	always_comb begin
		logic [CHAN_W-1:0] c;
		logic [CHAN_W-1:0] lo;
		logic [CHAN_W:0]   sum;
		logic [CHAN_W-1:0] hi;
		transp = 1'b1;
		for (int i = 0; i < NUM_CHAN; i++) begin
			c   = pixel.pixel_color[i*CHAN_W +: CHAN_W];
			lo  = key_color[i*CHAN_W +: CHAN_W];
			sum = {1'b0, lo} + {1'b0, tolerance[i*CHAN_W +: CHAN_W]};
			hi  = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
			if (c < lo || c > hi) begin
				transp = 1'b0;
			end
		end
	end

	assign rend = pixel.row_end || pixel.frame_end || (col_q == COL_W'(MAX_WIDTH - 1));
	assign begin_col = run_open_q ? run_begin_q : col_q;

	always_comb begin
		ev.span_row  = row_q;
		ev.frame_end = pixel.frame_end;
		if (transp) begin
			ev.has_span   = run_open_q;
			ev.span_start = run_begin_q;
			ev.span_stop  = {1'b0, col_q};
		end else begin
			ev.has_span   = rend;
			ev.span_start = begin_col;
			ev.span_stop  = {1'b0, col_q} + POS_W'(1);
		end
	end

	assign ev_push = accept && (ev.has_span || pixel.frame_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			run_open_q  <= 1'b0;
			run_begin_q <= '0;
		end else if (accept) begin
			run_open_q <= !transp && !rend;
			if (!transp && !run_open_q) begin
				run_begin_q <= col_q;
			end
			if (rend) begin
				col_q <= '0;
				if (row_q != ROW_W'(MAX_HEIGHT - 1)) begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
			if (pixel.frame_end) begin
				row_q       <= '0;
				run_begin_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ckse_fifo.sv -----
// Four-entry queue of span events between the front and the back.
// Depends on ckse_pkg for the event type.
`timescale 1ns / 1ps
`default_nettype none
module ckse_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ckse_pkg::span_event_t push_data,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       head_valid,
	output ckse_pkg::span_event_t      head
);
	import ckse_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	span_event_t        entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     fill_q;
	logic               do_pop;

	assign full       = (fill_q == (PTR_W+1)'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (!push && do_pop) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ckse_back.sv -----
// Back of the span extractor: batch box and count, record sequencing, output register.
// Depends on ckse_pkg; drains events from ckse_fifo.
`timescale 1ns / 1ps
`default_nettype none
module ckse_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  ev_valid,
	input  wire ckse_pkg::span_event_t ev,
	output logic                       ev_pop,
	output logic                       record_valid,
	input  wire logic                  record_ready,
	output ckse_pkg::record_t          record
);
	import ckse_pkg::*;

	// Which record of the head event goes out next.
	typedef enum logic [2:0] {
		PH_SPAN = 3'b001,
		PH_FULL = 3'b010,
		PH_LAST = 3'b100
	} phase_t;

	phase_t           phase_q;
	logic [POS_W-1:0] left_q;
	logic [POS_W-1:0] top_q;
	logic [POS_W-1:0] right_q;
	logic [POS_W-1:0] bottom_q;
	logic [CNT_W-1:0] count_q;
	record_t          record_q;
	logic             record_valid_q;

	logic             fire;
	logic             emit_span;
	logic             emit_full;
	logic             emit_last;
	logic             batch_done;
	logic [POS_W-1:0] row_ext;
	logic [POS_W-1:0] row_next;
	record_t          rec_next;

	assign fire = ev_valid && (!record_valid_q || record_ready);

	always_comb begin
		emit_span = 1'b0;
		emit_full = 1'b0;
		emit_last = 1'b0;
		unique case (phase_q)
			PH_SPAN: begin
				emit_span = ev.has_span;
				emit_last = !ev.has_span;
			end
			PH_FULL: emit_full = 1'b1;
			PH_LAST: emit_last = 1'b1;
			default: emit_last = 1'b0;
		endcase
	end

	assign batch_done = (count_q == CNT_W'(BATCH_SIZE - 1));
	assign row_ext    = {1'b0, ev.span_row};
	assign row_next   = row_ext + POS_W'(1);

	always_comb begin
		rec_next = '0;
		if (emit_span) begin
			rec_next.record_kind = KIND_SPAN;
			rec_next.span_start  = ev.span_start;
			rec_next.span_stop   = ev.span_stop;
			rec_next.span_row    = ev.span_row;
		end else begin
			rec_next.record_kind = KIND_BATCH;
			rec_next.box_left    = left_q;
			rec_next.box_top     = top_q;
			rec_next.box_right   = right_q;
			rec_next.box_bottom  = bottom_q;
			rec_next.batch_count = count_q;
			rec_next.last        = emit_last;
		end
	end

	// The head leaves the queue once its final record has gone out.
	always_comb begin
		ev_pop = 1'b0;
		if (fire) begin
			priority if (emit_span) begin
				ev_pop = !batch_done && !ev.frame_end;
			end else if (emit_full) begin
				ev_pop = !ev.frame_end;
			end else begin
				ev_pop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			record_q <= rec_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SPAN;
			record_valid_q <= 1'b0;
			left_q         <= POS_W'(MAX_WIDTH);
			top_q          <= POS_W'(MAX_HEIGHT);
			right_q        <= '0;
			bottom_q       <= '0;
			count_q        <= '0;
		end else begin
			if (fire) begin
				record_valid_q <= 1'b1;
			end else if (record_ready) begin
				record_valid_q <= 1'b0;
			end
			if (fire) begin
				priority if (emit_span) begin
					if ({1'b0, ev.span_start} < left_q) begin
						left_q <= {1'b0, ev.span_start};
					end
					if (row_ext < top_q) begin
						top_q <= row_ext;
					end
					if (ev.span_stop > right_q) begin
						right_q <= ev.span_stop;
					end
					if (row_next > bottom_q) begin
						bottom_q <= row_next;
					end
					count_q <= count_q + CNT_W'(1);
					priority if (batch_done) begin
						phase_q <= PH_FULL;
					end else if (ev.frame_end) begin
						phase_q <= PH_LAST;
					end else begin
						phase_q <= PH_SPAN;
					end
				end else begin
					left_q   <= POS_W'(MAX_WIDTH);
					top_q    <= POS_W'(MAX_HEIGHT);
					right_q  <= '0;
					bottom_q <= '0;
					count_q  <= '0;
					phase_q  <= (emit_full && ev.frame_end) ? PH_LAST : PH_SPAN;
				end
			end
		end
	end

	assign record_valid = record_valid_q;
	assign record       = record_q;

endmodule
`default_nettype wire
